/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define AST_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define AST_IMPL(lbl, ante, cons)
`define AST_NEXT(lbl, ante, cons)
`endif

`endif

/* rtl/core/swm_pkg.sv */
// ----------------------------------------------------------------------------
// Sliding window median package
// Shared widths, register map and cell link type.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int MAX_WINDOW_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 32;

  localparam int SAMPLE_W   = 32;
  localparam int MEDIAN_W   = 32;
  localparam int WS_W       = 7;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int OQ_DEPTH   = 3;

  localparam logic [CFG_ADDR_W-3:0] REG_WINDOW_SIZE = 1'b0;
  localparam logic [WS_W-1:0]       WS_RESET        = 7'd1;

  typedef struct packed {
    logic gt;
    logic del_upto;
  } cell_flags_t;

endpackage

/* rtl/core/swm_if.sv */
// ----------------------------------------------------------------------------
// Sliding window median stream interfaces
// Valid/ready channels for samples in and medians out.
// ----------------------------------------------------------------------------
interface swm_in_if;
  logic                          valid;
  logic                          ready;
  logic [swm_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface swm_out_if;
  logic                          valid;
  logic                          ready;
  logic [swm_pkg::MEDIAN_W-1:0]  median;

  modport source (output valid, output median, input ready);
  modport sink   (input valid, input median, output ready);
endinterface

/* rtl/core/swm_cell.sv */
// ----------------------------------------------------------------------------
// Sorted window cell
// One slot of the sorted window: holds a value and its age, and on each
// transaction takes its new content from itself, a neighbor or the sample.
// ----------------------------------------------------------------------------
module swm_cell #(
  parameter int VW = swm_pkg::SAMPLE_BITS_DEF,
  parameter int AW = 6
) (
  input  logic                  clk,
  input  logic                  fire,
  input  logic [VW-1:0]         sample,
  input  logic [AW-1:0]         age_max,
  input  logic                  full,
  input  logic                  valid,
  input  logic [VW-1:0]         left_val,
  input  logic [AW-1:0]         left_age,
  input  swm_pkg::cell_flags_t  left_flg,
  input  logic [VW-1:0]         right_val,
  input  logic [AW-1:0]         right_age,
  input  swm_pkg::cell_flags_t  right_flg,
  output logic [VW-1:0]         val_r,
  output logic [AW-1:0]         age_r,
  output swm_pkg::cell_flags_t  flg
);

  logic          gt;
  logic          del_self;
  logic [VW-1:0] val_nxt;
  logic [AW-1:0] age_nxt;

  assign gt       = !valid || (sample < val_r);
  assign del_self = full && valid && (age_r == age_max);
  assign flg.gt       = gt;
  assign flg.del_upto = left_flg.del_upto | del_self;

  always_comb begin
    val_nxt = val_r;
    age_nxt = AW'(age_r + 1'b1);
    if (left_flg.del_upto) begin
      if (!gt) begin
        if (right_flg.gt) begin
          val_nxt = sample;
          age_nxt = '0;
        end else begin
          val_nxt = right_val;
          age_nxt = AW'(right_age + 1'b1);
        end
      end
    end else if (del_self) begin
      if (left_flg.gt) begin
        val_nxt = left_val;
        age_nxt = AW'(left_age + 1'b1);
      end else if (right_flg.gt) begin
        val_nxt = sample;
        age_nxt = '0;
      end else begin
        val_nxt = right_val;
        age_nxt = AW'(right_age + 1'b1);
      end
    end else begin
      if (left_flg.gt) begin
        val_nxt = left_val;
        age_nxt = AW'(left_age + 1'b1);
      end else if (gt) begin
        val_nxt = sample;
        age_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      val_r <= val_nxt;
      age_r <= age_nxt;
    end
  end

endmodule

/* rtl/core/swm_cfg.sv */
// ----------------------------------------------------------------------------
// Sliding window median register block
// APB-style window_size register with derived window length and median rank.
// ----------------------------------------------------------------------------
module swm_cfg #(
  parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF,
  parameter int KW         = $clog2(MAX_WINDOW + 1),
  parameter int IW         = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [swm_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [swm_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [swm_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready,
  output logic                            clear,
  output logic [KW-1:0]                   k_r,
  output logic [IW-1:0]                   med_idx_r
);

  localparam int WS_W = swm_pkg::WS_W;
  localparam int CW   = (KW > WS_W) ? KW : WS_W;

  logic            hit;
  logic [WS_W-1:0] ws_r;
  logic [WS_W-1:0] ws_nxt;
  logic [CW-1:0]   k_ext;
  logic [CW-1:0]   k_m1;

  assign hit    = cfg_paddr[swm_pkg::CFG_ADDR_W-1:2] == swm_pkg::REG_WINDOW_SIZE;
  assign clear  = cfg_psel && cfg_penable && cfg_pwrite && hit;
  assign ws_nxt = cfg_pwdata[WS_W-1:0];
  assign cfg_pready = 1'b1;
  assign cfg_prdata = hit ? swm_pkg::CFG_DATA_W'(ws_r) : '0;

  always_comb begin
    if (ws_nxt == '0) begin
      k_ext = CW'(1);
    end else if (CW'(ws_nxt) > CW'(MAX_WINDOW)) begin
      k_ext = CW'(MAX_WINDOW);
    end else begin
      k_ext = CW'(ws_nxt);
    end
    k_m1 = CW'(k_ext - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r      <= swm_pkg::WS_RESET;
      k_r       <= KW'(1);
      med_idx_r <= '0;
    end else if (clear) begin
      ws_r      <= ws_nxt;
      k_r       <= KW'(k_ext);
      med_idx_r <= IW'(k_m1 >> 1);
    end
  end

endmodule

/* rtl/core/swm_out_q.sv */
// ----------------------------------------------------------------------------
// Median output queue
// Small FIFO that decouples median capture from the result channel.
// ----------------------------------------------------------------------------
module swm_out_q #(
  parameter int DEPTH = swm_pkg::OQ_DEPTH,
  parameter int CNTW  = $clog2(DEPTH + 1),
  parameter int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  logic [swm_pkg::MEDIAN_W-1:0]   push_data,
  output logic [CNTW-1:0]                cnt_r,
  swm_out_if.source                      out_chan
);

  logic [swm_pkg::MEDIAN_W-1:0] q_r [DEPTH];
  logic [PW-1:0]                wp_r;
  logic [PW-1:0]                rp_r;
  logic                         pop;

  assign pop             = out_chan.valid && out_chan.ready;
  assign out_chan.valid  = cnt_r != '0;
  assign out_chan.median = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : PW'(wp_r + 1'b1);
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : PW'(rp_r + 1'b1);
      end
      cnt_r <= CNTW'(cnt_r + CNTW'(push) - CNTW'(pop));
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= push_data;
    end
  end

endmodule

/* rtl/core/sliding_window_median_unit.sv */
// ----------------------------------------------------------------------------
// Sliding window median unit
// Running lower median over the last window_size samples, kept in a sorted
// chain of cells that insert the new sample and drop the oldest in one step.
// ----------------------------------------------------------------------------
//  channel    | dir | transaction
//  in_chan    | in  | sample, valid/ready
//  out_chan   | out | median, valid/ready
//  cfg_*      | in  | APB write/read of window_size at byte 0
//
//  One sample per cycle while in_chan.ready is high; the cell chain updates in the accept cycle.
//  Once a sample completes the window, its median leaves the cell at the rank
//  index in the cycle after accept into a 3-entry output queue.
//  in_chan.ready drops only when queue count plus pending capture reaches 3.
//  Reset empties the window; window_size returns to 1.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sliding_window_median_unit #(
  parameter int MAX_WINDOW  = swm_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  swm_in_if.sink                          in_chan,
  swm_out_if.source                       out_chan,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [swm_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [swm_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [swm_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);

  localparam int KW    = $clog2(MAX_WINDOW + 1);
  localparam int IW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int MW    = swm_pkg::MEDIAN_W;
  localparam int DEPTH = swm_pkg::OQ_DEPTH;
  localparam int CNTW  = $clog2(DEPTH + 1);

  logic                  cfg_clear;
  logic [KW-1:0]         k_r;
  logic [IW-1:0]         med_idx_r;
  logic [KW-1:0]         fill_r;
  logic [KW-1:0]         fill_nxt;
  logic                  pend_r;
  logic                  fire;
  logic                  full;
  logic                  emit;
  logic [SAMPLE_BITS-1:0] s;
  logic [IW-1:0]         age_max;
  logic [CNTW-1:0]       oq_cnt;

  logic [SAMPLE_BITS-1:0] cell_val [MAX_WINDOW];
  logic [IW-1:0]          cell_age [MAX_WINDOW];
  swm_pkg::cell_flags_t   cell_flg [MAX_WINDOW];

  swm_cfg #(
    .MAX_WINDOW (MAX_WINDOW),
    .KW         (KW),
    .IW         (IW)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .clear       (cfg_clear),
    .k_r         (k_r),
    .med_idx_r   (med_idx_r)
  );

  assign s       = SAMPLE_BITS'(in_chan.sample);
  assign age_max = IW'(k_r - 1'b1);
  assign fire    = in_chan.valid && in_chan.ready;
  assign full    = fill_r == k_r;
  assign emit    = full || (KW'(fill_r + 1'b1) == k_r);
  assign in_chan.ready = ((CNTW + 1)'(oq_cnt) + (CNTW + 1)'(pend_r)) < (CNTW + 1)'(DEPTH);

  always_comb begin
    fill_nxt = fill_r;
    if (cfg_clear) begin
      fill_nxt = '0;
    end else if (fire && !full) begin
      fill_nxt = KW'(fill_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      pend_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      pend_r <= fire && emit;
    end
  end

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic [SAMPLE_BITS-1:0] l_val;
    logic [IW-1:0]          l_age;
    swm_pkg::cell_flags_t   l_flg;
    logic [SAMPLE_BITS-1:0] r_val;
    logic [IW-1:0]          r_age;
    swm_pkg::cell_flags_t   r_flg;

    if (i == 0) begin : g_head
      assign l_val = '0;
      assign l_age = '0;
      assign l_flg = '{gt: 1'b0, del_upto: 1'b0};
    end else begin : g_mid_l
      assign l_val = cell_val[i-1];
      assign l_age = cell_age[i-1];
      assign l_flg = cell_flg[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_tail
      assign r_val = '0;
      assign r_age = '0;
      assign r_flg = '{gt: 1'b1, del_upto: 1'b0};
    end else begin : g_mid_r
      assign r_val = cell_val[i+1];
      assign r_age = cell_age[i+1];
      assign r_flg = cell_flg[i+1];
    end

    swm_cell #(
      .VW (SAMPLE_BITS),
      .AW (IW)
    ) u_cell (
      .clk       (clk),
      .fire      (fire),
      .sample    (s),
      .age_max   (age_max),
      .full      (full),
      .valid     (fill_r > KW'(i)),
      .left_val  (l_val),
      .left_age  (l_age),
      .left_flg  (l_flg),
      .right_val (r_val),
      .right_age (r_age),
      .right_flg (r_flg),
      .val_r     (cell_val[i]),
      .age_r     (cell_age[i]),
      .flg       (cell_flg[i])
    );
  end

  swm_out_q #(
    .DEPTH (DEPTH),
    .CNTW  (CNTW)
  ) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (pend_r),
    .push_data (MW'(cell_val[med_idx_r])),
    .cnt_r     (oq_cnt),
    .out_chan  (out_chan)
  );

  `AST_IMPL(a_fill_bound, 1'b1, fill_r <= k_r)
  `AST_IMPL(a_capture_room, pend_r, oq_cnt < CNTW'(DEPTH))
  `AST_NEXT(a_full_emits, fire && full, pend_r)
  `AST_NEXT(a_clear_empties, cfg_clear, fill_r == '0)
  if (MAX_WINDOW > 1) begin : g_order_chk
    `AST_IMPL(a_sorted_head, fill_r >= KW'(2), cell_val[0] <= cell_val[1])
  end

endmodule

/* bench/tb_sliding_window_median_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window median unit testbench
// Walks a table of directed samples and register writes, then runs random
// phases over many window sizes and sample patterns. Every median is checked
// in order against the table value on typed rows, else against a shadow
// window kept in the bench, with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_sliding_window_median_unit;

  localparam int CFG_ADDR_W = swm_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W = swm_pkg::CFG_DATA_W;
  localparam int SAMPLE_W   = swm_pkg::SAMPLE_W;
  localparam int MEDIAN_W   = swm_pkg::MEDIAN_W;
  localparam int WS_W       = swm_pkg::WS_W;

  localparam logic [CFG_ADDR_W-1:0] WS_ADDR    = {swm_pkg::REG_WINDOW_SIZE, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR = {~swm_pkg::REG_WINDOW_SIZE, 2'b00};
  localparam int DRAIN_CYCLES  = 4;
  localparam int TOTAL_SAMPLES = 1150;
  localparam int NUM_ROWS      = 24;
  localparam int NUM_FIXED     = 10;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;
  typedef enum int {PAT_RANDOM, PAT_TIES, PAT_EXTREMES, PAT_RAMP} pattern_t;

  typedef struct packed {
    row_kind_t               kind;
    logic [CFG_ADDR_W-1:0]   addr;
    logic [31:0]             data;
    logic                    typed;
    logic [MEDIAN_W-1:0]     want;
  } dir_row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_psel;
  logic                    cfg_penable;
  logic                    cfg_pwrite;
  logic [CFG_ADDR_W-1:0]   cfg_paddr;
  logic [CFG_DATA_W-1:0]   cfg_pwdata;
  logic [CFG_DATA_W-1:0]   cfg_prdata;
  logic                    cfg_pready;

  swm_in_if  in_bus ();
  swm_out_if out_bus ();

  sliding_window_median_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_bus),
    .out_chan    (out_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  bit [WS_W-1:0]      ws_shadow;
  bit [SAMPLE_W-1:0]  window_hist[$];
  bit [MEDIAN_W-1:0]  expected_medians[$];
  int                 fail_count;
  int                 samples_sent;
  bit                 quiet;
  dir_row_t           directed_rows [NUM_ROWS];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_sliding_window_median_unit NOT OK");
    $finish;
  end

  function automatic int unsigned span_of(bit [WS_W-1:0] v);
    if (v == 0) return 1;
    if (v > swm_pkg::MAX_WINDOW_DEF) return swm_pkg::MAX_WINDOW_DEF;
    return 32'(v);
  endfunction

  function automatic bit [MEDIAN_W-1:0] lower_median_of(input bit [SAMPLE_W-1:0] vals[$]);
    bit [SAMPLE_W-1:0] srt[$];
    bit [SAMPLE_W-1:0] t;
    int j;
    srt = vals;
    for (int i = 1; i < srt.size(); i++) begin
      t = srt[i];
      j = i - 1;
      while (j >= 0 && srt[j] > t) begin
        srt[j+1] = srt[j];
        j--;
      end
      srt[j+1] = t;
    end
    return srt[(srt.size() + 1) / 2 - 1];
  endfunction

  function automatic bit predict_median(input bit [SAMPLE_W-1:0] s,
                                        output bit [MEDIAN_W-1:0] med);
    int unsigned k;
    k = span_of(ws_shadow);
    med = '0;
    window_hist.insert(window_hist.size(), s);
    if (window_hist.size() > k) void'(window_hist.pop_front());
    if (window_hist.size() != k) return 1'b0;
    med = lower_median_of(window_hist);
    return 1'b1;
  endfunction

  function automatic bit [SAMPLE_W-1:0] make_sample(pattern_t pat, int idx);
    case (pat)
      PAT_RANDOM: return $urandom();
      PAT_TIES:   return $urandom_range(0, 3);
      PAT_EXTREMES: begin
        case ($urandom_range(0, 2))
          0:       return '0;
          1:       return '1;
          default: return $urandom();
        endcase
      end
      default:    return idx[0] ? 32'hFFFF_FFFF - idx : 32'(idx);
    endcase
  endfunction

  // wait for the pipe to empty out completely
  task automatic settle();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (expected_medians.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                          input logic [CFG_DATA_W-1:0] data,
                          output logic [CFG_DATA_W-1:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
    logic [CFG_DATA_W-1:0] rd;
    settle();
    apb_xfer(1'b1, addr, data, rd);
    if (addr == WS_ADDR) begin
      ws_shadow = data[WS_W-1:0];
      window_hist.delete();
    end
    @(posedge clk);
    if (addr == WS_ADDR) begin
      apb_xfer(1'b0, addr, '0, rd);
      if (rd !== CFG_DATA_W'(ws_shadow)) begin
        $error("window_size mismatch: expected %0d, actual %0d", ws_shadow, rd);
        fail_count++;
      end
      @(posedge clk);
    end
  endtask

  task automatic send_sample(input bit [SAMPLE_W-1:0] s, input bit typed,
                             input bit [MEDIAN_W-1:0] want);
    int gap;
    bit got;
    bit [MEDIAN_W-1:0] med;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid  <= 1'b1;
    in_bus.sample <= s;
    do @(posedge clk); while (!(in_bus.valid && in_bus.ready));
    samples_sent++;
    got = predict_median(s, med);
    if (got) expected_medians.insert(expected_medians.size(), typed ? want : med);
  endtask

  // median sink
  initial begin
    int gap;
    bit [MEDIAN_W-1:0] want;
    out_bus.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!(out_bus.valid && out_bus.ready));
      if (expected_medians.size() == 0) begin
        $error("median unexpected: expected none, actual %h", out_bus.median);
        fail_count++;
      end else begin
        want = expected_medians.pop_front();
        if (out_bus.median !== want) begin
          $error("median mismatch: expected %h, actual %h", want, out_bus.median);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int unsigned fixed_sizes [NUM_FIXED];
    bit [WS_W-1:0] size;
    pattern_t pat;
    int n;
    int p;

    rst_n         <= 1'b0;
    cfg_psel      <= 1'b0;
    cfg_penable   <= 1'b0;
    cfg_pwrite    <= 1'b0;
    cfg_paddr     <= '0;
    cfg_pwdata    <= '0;
    in_bus.valid  <= 1'b0;
    in_bus.sample <= '0;
    ws_shadow     = swm_pkg::WS_RESET;
    fail_count    = 0;
    samples_sent  = 0;
    quiet         = 1'b0;
    fixed_sizes   = '{1, 2, 3, 64, 65, 127, 0, 7, 16, 33};

    // size 1 passes samples; size 0 acts as 1; the spare address leaves the window alone
    directed_rows = '{
      '{ROW_SAMPLE, WS_ADDR,    32'h0000_0000, 1'b1, 32'h0000_0000},
      '{ROW_SAMPLE, WS_ADDR,    32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
      '{ROW_SAMPLE, WS_ADDR,    32'h0000_0001, 1'b1, 32'h0000_0001},
      '{ROW_SAMPLE, WS_ADDR,    32'h8000_0000, 1'b1, 32'h8000_0000},
      '{ROW_SAMPLE, WS_ADDR,    32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
      '{ROW_WRITE,  WS_ADDR,    32'h0000_0000, 1'b0, 32'h0},
      '{ROW_SAMPLE, WS_ADDR,    32'hA5A5_A5A5, 1'b1, 32'hA5A5_A5A5},
      '{ROW_SAMPLE, WS_ADDR,    32'h5A5A_5A5A, 1'b1, 32'h5A5A_5A5A},
      '{ROW_WRITE,  WS_ADDR,    32'h0000_0002, 1'b0, 32'h0},
      '{ROW_SAMPLE, WS_ADDR,    32'h0000_0009, 1'b0, 32'h0},
      '{ROW_SAMPLE, WS_ADDR,    32'h0000_0003, 1'b1, 32'h0000_0003},
      '{ROW_SAMPLE, WS_ADDR,    32'hFFFF_FFFF, 1'b1, 32'h0000_0003},
      '{ROW_WRITE,  WS_ADDR,    32'h0000_0004, 1'b0, 32'h0},
      '{ROW_SAMPLE, WS_ADDR,    32'h0000_000A, 1'b0, 32'h0},
      '{ROW_SAMPLE, WS_ADDR,    32'h0000_000A, 1'b0, 32'h0},
      '{ROW_SAMPLE, WS_ADDR,    32'h0000_000A, 1'b0, 32'h0},
      '{ROW_SAMPLE, WS_ADDR,    32'h0000_0002, 1'b1, 32'h0000_000A},
      '{ROW_WRITE,  SPARE_ADDR, 32'h0000_0001, 1'b0, 32'h0},
      '{ROW_SAMPLE, WS_ADDR,    32'h0000_0001, 1'b1, 32'h0000_0002},
      '{ROW_WRITE,  WS_ADDR,    32'h0000_0003, 1'b0, 32'h0},
      '{ROW_SAMPLE, WS_ADDR,    32'hFFFF_FFFF, 1'b0, 32'h0},
      '{ROW_SAMPLE, WS_ADDR,    32'h0000_0000, 1'b0, 32'h0},
      '{ROW_SAMPLE, WS_ADDR,    32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
      '{ROW_WRITE,  WS_ADDR,    32'h0000_0001, 1'b0, 32'h0}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_WRITE) begin
        write_reg(directed_rows[r].addr, directed_rows[r].data);
      end else begin
        send_sample(directed_rows[r].data, directed_rows[r].typed, directed_rows[r].want);
      end
    end

    p = 0;
    while (samples_sent < TOTAL_SAMPLES) begin
      if (p < NUM_FIXED) begin
        size = WS_W'(fixed_sizes[p]);
      end else if ($urandom_range(0, 5) == 0) begin
        size = WS_W'($urandom_range(0, 127));
      end else begin
        size = WS_W'($urandom_range(1, 12));
      end
      if (p % 7 == 3) write_reg(SPARE_ADDR, $urandom());
      write_reg(WS_ADDR, ($urandom() & ~32'h7F) | 32'(size));
      quiet = ($urandom_range(0, 3) == 0);
      pat   = pattern_t'($urandom_range(0, 3));
      n     = span_of(size) + $urandom_range(16, 48);
      for (int i = 0; i < n; i++) begin
        if (i == n / 2 && p % 3 == 0) settle();
        send_sample(make_sample(pat, i), 1'b0, '0);
      end
      p++;
    end

    settle();
    if (fail_count == 0) begin
      $display("tb_sliding_window_median_unit OK");
    end else begin
      $display("tb_sliding_window_median_unit NOT OK");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/swm_pkg.sv
rtl/core/swm_if.sv
rtl/core/swm_cell.sv
rtl/core/swm_cfg.sv
rtl/core/swm_out_q.sv
rtl/core/sliding_window_median_unit.sv
bench/tb_sliding_window_median_unit.sv
